[rtl/pib_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and request layouts for the point-in-box classifier.
// Used by every module under rtl except pib_ram; depends on nothing else.
package pib_pkg;

  localparam int MAX_BOXES   = 64;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_EDGES   = 3;
  localparam int NUM_AXES    = 3;

  localparam int COORD_W  = 20;
  localparam int CORNER_W = COORD_W * NUM_AXES;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 2;

  localparam int BOX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  localparam int COUNT_REG_W = 7;
  localparam int SLOT_W      = 6;
  localparam int SEL_W       = 2;
  localparam int HIT_W       = 6;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOX_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_FLOOR = 1'b1;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Default floor is -2.0 in Q11.8.
  localparam logic signed [COORD_W-1:0] FLOOR_RESET = -20'sd512;

  localparam int IN_BITS    = SLOT_W + SEL_W + CORNER_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = HIT_W + CORNER_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  // One box test in flight along the cell row. Vector components are
  // rotated by each cell so that the next axis always sits at index 0.
  typedef struct packed {
    logic                                   valid;
    logic                                   last;
    logic [BOX_W-1:0]                       box;
    diff_t [NUM_EDGES-1:0][NUM_AXES-1:0]    ev;
    diff_t [NUM_AXES-1:0]                   v0;
    diff_t [NUM_EDGES-1:0][NUM_AXES-1:0]    vk;
    dot_t  [NUM_EDGES-1:0]                  dot0;
    dot_t  [NUM_EDGES-1:0]                  dotk;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [BOX_W-1:0] box;
    logic             hit;
  } verdict_t;

endpackage

[rtl/pib_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module pib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pib_cell.sv]
`timescale 1ns / 1ps
// One cell of the dot-product row: adds one axis term to all six dot products.
// Depends on pib_pkg.
module pib_cell import pib_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  lane_t lane_in,
  output lane_t lane_out
);

  lane_t nxt;
  logic signed [PROD_W-1:0] prod0 [NUM_EDGES];
  logic signed [PROD_W-1:0] prodk [NUM_EDGES];

  // Multiply the axis at index 0, accumulate, then rotate the vectors so the
  // neighbor sees the following axis at index 0.
  always_comb begin
    nxt = lane_in;
    for (int k = 0; k < NUM_EDGES; k++) begin
      prod0[k] = $signed(lane_in.ev[k][0]) * $signed(lane_in.v0[0]);
      prodk[k] = $signed(lane_in.ev[k][0]) * $signed(lane_in.vk[k][0]);
      nxt.dot0[k] = $signed(lane_in.dot0[k]) + DOT_W'(prod0[k]);
      nxt.dotk[k] = $signed(lane_in.dotk[k]) + DOT_W'(prodk[k]);
      nxt.ev[k] = {lane_in.ev[k][0], lane_in.ev[k][NUM_AXES-1:1]};
      nxt.vk[k] = {lane_in.vk[k][0], lane_in.vk[k][NUM_AXES-1:1]};
    end
    nxt.v0 = {lane_in.v0[0], lane_in.v0[NUM_AXES-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out <= nxt;
    end
  end

endmodule

[rtl/pib_judge.sv]
`timescale 1ns / 1ps
// Sign test at the end of the cell row: turns six dot products into a box verdict.
// Depends on pib_pkg.
module pib_judge import pib_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lane_t    lane_in,
  output verdict_t verdict
);

  logic enclosed;

  // Each edge needs two nonzero dot products of opposite sign.
  always_comb begin
    enclosed = 1'b1;
    for (int k = 0; k < NUM_EDGES; k++) begin
      if ((lane_in.dot0[k] == '0) || (lane_in.dotk[k] == '0) ||
          (lane_in.dot0[k][DOT_W-1] == lane_in.dotk[k][DOT_W-1])) begin
        enclosed = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else begin
      verdict.valid <= lane_in.valid;
      verdict.last  <= lane_in.last;
      verdict.box   <= lane_in.box;
      verdict.hit   <= enclosed;
    end
  end

endmodule

[rtl/point_in_box_classifier.sv]
`timescale 1ns / 1ps
// Top level of the point-in-box classifier: request channels, box store,
// sequencer and the row of dot-product cells. Depends on pib_pkg and all rtl modules.
//
// Usage:
//   Requests enter on the s_* stream. s_tuser selects the kind: a load request
//   writes one corner (0, 1, 2 or 3) of one box into the corner banks, a
//   classify request tests a point against boxes 0 .. n-1 in order, where n
//   is box_count clamped to 64. Each classify request produces exactly one
//   result on the m_* stream; a load request produces none. Configuration is
//   to be written through cfg_we, cfg_index and cfg_data only while the block is idle; the block does not enforce this.
// Timing:
//   A classify request walks the boxes one per cycle through the four corner
//   banks (one read each per cycle) and a row of three cells, one cell per
//   axis; the next request can be taken in the cycle its result is first
//   offered. For a point at or below the floor, or n equal to zero, no boxes
//   are walked and the result is offered straight from the done state. The
//   box walk always runs to the end so the first hit in box order is kept.
// Reset and stalls:
//   rst clears the sequencer, the output valid and the registers (box_count 0,
//   height_floor -2.0). The corner banks are not cleared. The result sits in
//   an output register; while it is stalled the block still takes the next
//   request and only holds a finished result until the register frees up.
module point_in_box_classifier import pib_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Input requests.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata fields from bit 0: box_index[5:0], corner[7:6], coord_x[27:8],
  // coord_y[47:28], coord_z[67:48], zero pad.
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // s_tuser fields from bit 0: func.
  input  logic                   s_tuser,
  // Results.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata fields from bit 0: box_hit[5:0], point_x[25:6], point_y[45:26],
  // point_z[65:46], zero pad.
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // m_tuser fields from bit 0: background flag.
  output logic                   m_tuser,
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int CMP_W = (CNT_W > COUNT_REG_W) ? CNT_W : COUNT_REG_W;

  logic [1:0] state;

  logic [COUNT_REG_W-1:0] box_count;
  coord_t                 height_floor;

  logic                   accept;
  logic [SLOT_W-1:0]      in_slot;
  logic [SEL_W-1:0]       in_sel;
  coord_t                 in_pnt [NUM_AXES];
  logic                   load_ok;
  logic [CMP_W-1:0]       cnt_req;
  logic [CNT_W-1:0]       n_eff;

  coord_t                 pnt [NUM_AXES];
  logic [CNT_W-1:0]       cnt;
  logic                   found;
  logic [BOX_W-1:0]       hit_box;

  logic                   iss_valid;
  logic                   iss_last;
  logic [BOX_W-1:0]       iss_box;

  logic [CORNER_W-1:0]    rd [NUM_CORNERS];
  lane_t                  prep;
  lane_t                  chain [NUM_AXES+1];
  verdict_t               vd;

  logic                   out_bg;
  logic [HIT_W-1:0]       out_hit;
  coord_t                 out_pnt [NUM_AXES];

  function automatic diff_t sub_ext(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // Request fields.
  assign accept  = s_tvalid && s_tready;
  assign in_slot = s_tdata[SLOT_W-1:0];
  assign in_sel  = s_tdata[SLOT_W +: SEL_W];
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_in
    assign in_pnt[a] = s_tdata[SLOT_W + SEL_W + a*COORD_W +: COORD_W];
  end

  assign s_tready = (state == ST_IDLE);
  assign load_ok  = accept && (s_tuser == FUNC_LOAD) && (int'(in_slot) < MAX_BOXES);

  // Box counts beyond the store size are clamped.
  assign cnt_req = CMP_W'(box_count);
  assign n_eff   = (cnt_req > CMP_W'(MAX_BOXES)) ? CNT_W'(MAX_BOXES) : CNT_W'(cnt_req);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count    <= '0;
      height_floor <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_COUNT:    box_count    <= cfg_data[COUNT_REG_W-1:0];
        CFG_HEIGHT_FLOOR: height_floor <= cfg_data;
        default:          ;
      endcase
    end
  end

  // One bank per stored corner, so all corners of a box are read together.
  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_bank
    pib_ram #(
      .WIDTH(CORNER_W),
      .DEPTH(MAX_BOXES)
    ) u_bank (
      .clk  (clk),
      .we   (load_ok && (in_sel == SEL_W'(c))),
      .waddr(BOX_W'(in_slot)),
      .wdata(s_tdata[SLOT_W + SEL_W +: CORNER_W]),
      .raddr(cnt[BOX_W-1:0]),
      .rdata(rd[c])
    );
  end

  // Edge and point vectors for the box just read out of the banks.
  always_comb begin
    coord_t c0;
    coord_t ck;
    prep = '0;
    prep.valid = iss_valid;
    prep.last  = iss_last;
    prep.box   = iss_box;
    for (int a = 0; a < NUM_AXES; a++) begin
      c0 = rd[0][a*COORD_W +: COORD_W];
      prep.v0[a] = sub_ext(c0, pnt[a]);
      for (int k = 0; k < NUM_EDGES; k++) begin
        ck = rd[k+1][a*COORD_W +: COORD_W];
        prep.ev[k][a] = sub_ext(c0, ck);
        prep.vk[k][a] = sub_ext(ck, pnt[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0] <= prep;
    end
  end

  // Row of cells, one per axis.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_cell
    pib_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .lane_in (chain[a]),
      .lane_out(chain[a+1])
    );
  end

  pib_judge u_judge (
    .clk    (clk),
    .rst    (rst),
    .lane_in(chain[NUM_AXES]),
    .verdict(vd)
  );

  // Sequencer: takes requests, walks the boxes, keeps the first hit and
  // hands the result to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      found     <= 1'b0;
      cnt       <= '0;
      iss_valid <= 1'b0;
    end else begin
      iss_valid <= (state == ST_RUN);
      iss_last  <= (cnt == CNT_W'(n_eff - 1'b1));
      iss_box   <= cnt[BOX_W-1:0];

      // In the done state the output register is handled below.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == FUNC_CLASSIFY)) begin
            pnt     <= in_pnt;
            found   <= 1'b0;
            hit_box <= '0;
            cnt     <= '0;
            if ((in_pnt[NUM_AXES-1] > height_floor) && (n_eff != '0)) begin
              state <= ST_RUN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(n_eff - 1'b1)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (vd.valid && vd.last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_bg   <= !found;
            out_hit  <= HIT_W'(hit_box);
            out_pnt  <= pnt;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Verdicts arrive in box order; only the first hit counts. No verdict is
      // ever in flight while the sequencer is idle.
      if ((state != ST_IDLE) && vd.valid && vd.hit && !found) begin
        found   <= 1'b1;
        hit_box <= vd.box;
      end
    end
  end

  assign m_tdata = OUT_DATA_W'({out_pnt[2], out_pnt[1], out_pnt[0], out_hit});
  assign m_tuser = out_bg;

endmodule
